// ===== hdl/afs_pkg.sv =====
// ============================================================================
// afs_pkg
// Shared types and constants for the arming and failsafe supervisor: tick and
// result payloads, mode codes, register indexes and register reset values.
// ============================================================================
package afs_pkg;

    // mode codes
    localparam logic [1:0] MODE_DISARMED    = 2'd0;
    localparam logic [1:0] MODE_ARMED       = 2'd1;
    localparam logic [1:0] MODE_CALIBRATING = 2'd2;
    localparam logic [1:0] MODE_FAILSAFE    = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SWITCH_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_SWITCH_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_SWITCH_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_DEAD_ZONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_TIMEOUT_MS = 3'd5;

    // register reset values
    localparam logic [11:0] RST_CAL_SWITCH_HIGH     = 12'd1700;
    localparam logic [11:0] RST_ARM_SWITCH_HIGH     = 12'd1700;
    localparam logic [11:0] RST_ARM_SWITCH_LOW      = 12'd1300;
    localparam logic [11:0] RST_THROTTLE_DEAD_ZONE  = 12'd1050;
    localparam logic [15:0] RST_DEBOUNCE_TICKS      = 16'd50;
    localparam logic [31:0] RST_FAILSAFE_TIMEOUT_MS = 32'd1000;

    // one control tick
    typedef struct packed {
        logic [11:0] arm_pulse;
        logic [11:0] cal_pulse;
        logic [11:0] throttle_pulse;
        logic        link_lost;
        logic [31:0] now_ms;
    } afs_in_t;

    // one result
    typedef struct packed {
        logic [1:0] mode;
        logic       do_arm;
        logic       do_disarm;
        logic       do_calibrate;
        logic       clear_loops;
        logic       motors_idle;
        logic       run_control;
    } afs_out_t;

endpackage

// ===== hdl/arming_failsafe_supervisor.sv =====
// ============================================================================
// arming_failsafe_supervisor
// Debounced arm/disarm, one-shot calibration before first arm, and a link
// loss failsafe that recovers to armed or disarms after a timeout.
// ============================================================================
//
//  channel   ports                          width   direction
//  -------   -----------------------------  ------  ---------
//  tick      s_valid / s_ready / s_data     69      in
//  result    m_valid / m_ready / m_data     8       out
//  config    cfg_we / cfg_addr / cfg_wdata  3 + 32  in
//
//  A tick goes through the input register and then the result register;
//  one tick is accepted every cycle unless the result stalls. The supervisor
//  state is updated in the same cycle that moves a tick from the input
//  register into the result register. A stalled result holds the result
//  register; the input register keeps taking one more tick, then s_ready
//  drops until m_ready returns. Synchronous active low reset puts the block
//  disarmed with the register reset values loaded.
//
module arming_failsafe_supervisor (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  afs_pkg::afs_in_t                         s_data,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output afs_pkg::afs_out_t                        m_data,
    input  logic                                     cfg_we,
    input  logic [afs_pkg::CFG_IDX_W-1:0]            cfg_addr,
    input  logic [afs_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
    import afs_pkg::*;

    // configuration registers
    logic [11:0] cal_switch_high_reg;
    logic [11:0] arm_switch_high_reg;
    logic [11:0] arm_switch_low_reg;
    logic [11:0] throttle_dead_zone_reg;
    logic [15:0] debounce_ticks_reg;
    logic [31:0] failsafe_timeout_ms_reg;

    // pipeline registers
    logic     in_valid_reg;
    afs_in_t  in_data_reg;
    logic     out_valid_reg;
    afs_out_t out_data_reg;

    // supervisor state
    logic [1:0]  arm_mode_reg,         arm_mode_next;
    logic [15:0] arm_count_reg,        arm_count_next;
    logic [15:0] disarm_count_reg,     disarm_count_next;
    logic        cal_prev_high_reg,    cal_prev_high_next;
    logic        cal_primed_reg,       cal_primed_next;
    logic        ever_armed_reg,       ever_armed_next;
    logic [31:0] lost_since_reg,       lost_since_next;
    logic        lost_since_valid_reg, lost_since_valid_next;

    afs_out_t result_next;
    logic     advance;
    logic     fire;

    // handshake: result register frees when empty or taken
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_switch_high_reg     <= RST_CAL_SWITCH_HIGH;
            arm_switch_high_reg     <= RST_ARM_SWITCH_HIGH;
            arm_switch_low_reg      <= RST_ARM_SWITCH_LOW;
            throttle_dead_zone_reg  <= RST_THROTTLE_DEAD_ZONE;
            debounce_ticks_reg      <= RST_DEBOUNCE_TICKS;
            failsafe_timeout_ms_reg <= RST_FAILSAFE_TIMEOUT_MS;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CAL_SWITCH_HIGH:     cal_switch_high_reg     <= cfg_wdata[11:0];
                REG_ARM_SWITCH_HIGH:     arm_switch_high_reg     <= cfg_wdata[11:0];
                REG_ARM_SWITCH_LOW:      arm_switch_low_reg      <= cfg_wdata[11:0];
                REG_THROTTLE_DEAD_ZONE:  throttle_dead_zone_reg  <= cfg_wdata[11:0];
                REG_DEBOUNCE_TICKS:      debounce_ticks_reg      <= cfg_wdata[15:0];
                REG_FAILSAFE_TIMEOUT_MS: failsafe_timeout_ms_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-tick supervisor logic
    always_comb begin
        logic        cal_high;
        logic        prev_high;
        logic [15:0] cnt_inc;
        logic [31:0] since;
        logic [31:0] elapsed;

        cal_high  = in_data_reg.cal_pulse > cal_switch_high_reg;
        prev_high = cal_primed_reg ? cal_prev_high_reg : cal_high;
        cnt_inc   = '0;
        since     = lost_since_valid_reg ? lost_since_reg : in_data_reg.now_ms;
        elapsed   = in_data_reg.now_ms - since;

        arm_mode_next         = arm_mode_reg;
        arm_count_next        = arm_count_reg;
        disarm_count_next     = disarm_count_reg;
        cal_prev_high_next    = cal_prev_high_reg;
        cal_primed_next       = cal_primed_reg;
        ever_armed_next       = ever_armed_reg;
        lost_since_next       = lost_since_reg;
        lost_since_valid_next = lost_since_valid_reg;
        result_next           = '0;

        unique case (arm_mode_reg)
            MODE_DISARMED: begin
                cal_primed_next = 1'b1;
                if (!ever_armed_reg && cal_high && !prev_high) begin
                    // calibrate switch edge before first arm
                    cal_prev_high_next = 1'b1;
                    arm_mode_next      = MODE_CALIBRATING;
                end else begin
                    cal_prev_high_next = cal_high ? prev_high : 1'b0;
                    if (in_data_reg.arm_pulse > arm_switch_high_reg &&
                        in_data_reg.throttle_pulse < throttle_dead_zone_reg) begin
                        cnt_inc = arm_count_reg + 16'd1;
                        if (cnt_inc >= debounce_ticks_reg) begin
                            arm_count_next     = '0;
                            result_next.do_arm = 1'b1;
                            arm_mode_next      = MODE_ARMED;
                        end else begin
                            arm_count_next = cnt_inc;
                        end
                    end else begin
                        arm_count_next = '0;
                    end
                end
            end
            MODE_ARMED: begin
                ever_armed_next    = 1'b1;
                cal_prev_high_next = cal_high;
                if (in_data_reg.link_lost) begin
                    arm_mode_next = MODE_FAILSAFE;
                end else if (in_data_reg.arm_pulse < arm_switch_low_reg &&
                             disarm_count_reg + 16'd1 >= debounce_ticks_reg) begin
                    // debounced disarm
                    disarm_count_next       = '0;
                    result_next.do_disarm   = 1'b1;
                    result_next.clear_loops = 1'b1;
                    arm_mode_next           = MODE_DISARMED;
                end else begin
                    if (in_data_reg.arm_pulse < arm_switch_low_reg) begin
                        disarm_count_next = disarm_count_reg + 16'd1;
                    end else begin
                        disarm_count_next = '0;
                    end
                    if (in_data_reg.throttle_pulse > throttle_dead_zone_reg) begin
                        result_next.run_control = 1'b1;
                    end else begin
                        result_next.clear_loops = 1'b1;
                        result_next.motors_idle = 1'b1;
                    end
                end
            end
            MODE_CALIBRATING: begin
                result_next.do_calibrate = 1'b1;
                arm_mode_next            = MODE_DISARMED;
            end
            MODE_FAILSAFE: begin
                result_next.motors_idle = 1'b1;
                lost_since_next         = since;
                lost_since_valid_next   = 1'b1;
                if (!in_data_reg.link_lost) begin
                    lost_since_valid_next = 1'b0;
                    arm_mode_next         = MODE_ARMED;
                end else if (elapsed > failsafe_timeout_ms_reg) begin
                    lost_since_valid_next   = 1'b0;
                    result_next.do_disarm   = 1'b1;
                    result_next.clear_loops = 1'b1;
                    arm_mode_next           = MODE_DISARMED;
                end
            end
            default: ;
        endcase
        result_next.mode = arm_mode_next;
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result_next;
        end
    end

    // supervisor state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_mode_reg         <= MODE_DISARMED;
            arm_count_reg        <= '0;
            disarm_count_reg     <= '0;
            cal_prev_high_reg    <= 1'b0;
            cal_primed_reg       <= 1'b0;
            ever_armed_reg       <= 1'b0;
            lost_since_reg       <= '0;
            lost_since_valid_reg <= 1'b0;
        end else if (fire) begin
            arm_mode_reg         <= arm_mode_next;
            arm_count_reg        <= arm_count_next;
            disarm_count_reg     <= disarm_count_next;
            cal_prev_high_reg    <= cal_prev_high_next;
            cal_primed_reg       <= cal_primed_next;
            ever_armed_reg       <= ever_armed_next;
            lost_since_reg       <= lost_since_next;
            lost_since_valid_reg <= lost_since_valid_next;
        end
    end

endmodule
